FILE: src/iict_pkg.sv
// Shared types and constants for the inverted index chain table.
// No dependencies; the chain table refers to this package by scoped names.
package iict_pkg;

	localparam int ATOM_COUNT = 256;
	localparam int POOL_SIZE  = 1024;
	localparam int IDX_W      = 11;
	localparam int ENT_W      = 10;
	localparam int ATOM_W     = 8;
	localparam int CID_W      = 8;

	localparam logic [IDX_W-1:0] NONE = IDX_W'(POOL_SIZE);

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_HEAD   = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_SKIP     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [ATOM_W-1:0] atom_key;
		logic              atom_is_simple;
		logic [CID_W-1:0]  concept_id;
		logic [ENT_W-1:0]  entry_to_read;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] entry_index;
		logic [CID_W-1:0] entry_concept;
		logic [IDX_W-1:0] entry_next;
	} out_item_t;

endpackage

FILE: src/iict_stream_if.sv
// Valid/ready stream interface carrying one item per handshake.
// Payload type is given at instantiation; uses no package items directly.
interface iict_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/inverted_index_chain_table.sv
// Inverted index chain table: per-atom linked chains in a shared entry pool.
// get_head/read_entry: head, then result state. add/remove: head, then fetch and
// compare per chain entry walked, then free (remove) or alloc, pop and link (add;
// alloc alone when the pool is empty). One item at a time; the walk loop (one
// link-memory read per step) sets the rate, and a stalled output holds the block in
// its result state. After reset a clearing pass sets links to none, fills the free
// stack and clears heads; no item is taken. Depends on iict_pkg and iict_stream_if.
module inverted_index_chain_table (
	input  logic          clk,
	input  logic          arst_n,
	iict_stream_if.sink   in_ch,
	iict_stream_if.source out_ch
);

	typedef enum logic [9:0] {
		S_SWEEP = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_HEAD  = 10'b0000000100,
		S_FETCH = 10'b0000001000,
		S_CMP   = 10'b0000010000,
		S_FREE  = 10'b0000100000,
		S_ALLOC = 10'b0001000000,
		S_POP   = 10'b0010000000,
		S_LINK  = 10'b0100000000,
		S_RES   = 10'b1000000000
	} state_t;

	localparam int IW = iict_pkg::IDX_W;
	localparam int EW = iict_pkg::ENT_W;
	localparam int AW = iict_pkg::ATOM_W;
	localparam int CW = iict_pkg::CID_W;

	// Storage
	logic [IW-1:0] heads_mem [iict_pkg::ATOM_COUNT];
	logic [CW-1:0] con_mem   [iict_pkg::POOL_SIZE];
	logic [IW-1:0] link_mem  [iict_pkg::POOL_SIZE];
	logic [EW-1:0] free_mem  [iict_pkg::POOL_SIZE];

	state_t              state_q;
	logic [EW-1:0]       sweep_q;
	logic [IW-1:0]       free_count_q;
	iict_pkg::in_item_t  item_q;
	logic [IW-1:0]       e_q, prev_q, ne_q;
	logic [IW-1:0]       steps_q;
	iict_pkg::out_item_t res_q, out_q;
	logic                out_valid_q;

	// Registered read data
	logic [IW-1:0] head_rd_q;
	logic [CW-1:0] con_rd_q;
	logic [IW-1:0] link_rd_q;
	logic [EW-1:0] free_rd_q;

	// Write controls
	logic          head_we, con_we, link_we, free_we;
	logic [AW-1:0] head_waddr;
	logic [IW-1:0] head_wdata;
	logic [EW-1:0] con_waddr, link_waddr, free_waddr;
	logic [CW-1:0] con_wdata;
	logic [IW-1:0] link_wdata;
	logic [EW-1:0] free_wdata;
	logic [EW-1:0] ent_raddr;
	logic [EW-1:0] free_raddr;
	logic [IW-1:0] free_dec;

	logic accept;
	assign in_ch.ready  = (state_q == S_IDLE);
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// Address an entry from the request while idle, else from the walk pointer
	assign ent_raddr  = (state_q == S_IDLE) ? in_ch.data.entry_to_read : e_q[EW-1:0];
	assign free_dec   = free_count_q - IW'(1);
	assign free_raddr = free_dec[EW-1:0];

	always_comb begin
		head_we    = 1'b0;
		head_waddr = item_q.atom_key;
		head_wdata = iict_pkg::NONE;
		con_we     = 1'b0;
		con_waddr  = e_q[EW-1:0];
		con_wdata  = '0;
		link_we    = 1'b0;
		link_waddr = e_q[EW-1:0];
		link_wdata = iict_pkg::NONE;
		free_we    = 1'b0;
		free_waddr = free_count_q[EW-1:0];
		free_wdata = e_q[EW-1:0];
		case (state_q)
			S_SWEEP: begin
				// Clear one link entry and fill one free-stack slot per cycle; heads only below ATOM_COUNT
				link_we    = 1'b1;
				link_waddr = sweep_q;
				free_we    = 1'b1;
				free_waddr = sweep_q;
				free_wdata = sweep_q;
				if (sweep_q < EW'(iict_pkg::ATOM_COUNT)) begin
					head_we    = 1'b1;
					head_waddr = sweep_q[AW-1:0];
				end
			end
			S_CMP: begin
				// Bypass the matched entry on removal
				if (item_q.action == iict_pkg::ACT_REMOVE && con_rd_q == item_q.concept_id) begin
					if (!prev_q[IW-1]) begin
						link_we    = 1'b1;
						link_waddr = prev_q[EW-1:0];
						link_wdata = link_rd_q;
					end else begin
						head_we    = 1'b1;
						head_wdata = link_rd_q;
					end
				end
			end
			S_FREE: begin
				con_we  = 1'b1;
				link_we = 1'b1;
				free_we = (free_count_q < IW'(iict_pkg::POOL_SIZE));
			end
			S_POP: begin
				con_we     = 1'b1;
				con_waddr  = free_rd_q;
				con_wdata  = item_q.concept_id;
				link_we    = 1'b1;
				link_waddr = free_rd_q;
			end
			S_LINK: begin
				if (!prev_q[IW-1]) begin
					link_we    = 1'b1;
					link_waddr = prev_q[EW-1:0];
					link_wdata = ne_q;
				end else begin
					head_we    = 1'b1;
					head_wdata = ne_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (head_we) heads_mem[head_waddr] <= head_wdata;
		head_rd_q <= heads_mem[in_ch.data.atom_key];
	end

	always_ff @(posedge clk) begin
		if (con_we) con_mem[con_waddr] <= con_wdata;
		con_rd_q <= con_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_waddr] <= link_wdata;
		link_rd_q <= link_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_waddr] <= free_wdata;
		free_rd_q <= free_mem[free_raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) item_q <= in_ch.data;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			free_count_q <= IW'(iict_pkg::POOL_SIZE);
			out_valid_q  <= 1'b0;
			e_q          <= iict_pkg::NONE;
			prev_q       <= iict_pkg::NONE;
			ne_q         <= iict_pkg::NONE;
			steps_q      <= '0;
			res_q        <= '0;
			out_q        <= '0;
		end else begin
			// Drop the output once taken, unless a new result replaces it
			if (out_valid_q && out_ch.ready && state_q != S_RES) out_valid_q <= 1'b0;
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + EW'(1);
					if (sweep_q == EW'(iict_pkg::POOL_SIZE - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_HEAD;
				end
				S_HEAD: begin
					res_q.status        <= iict_pkg::ST_DONE;
					res_q.entry_index   <= iict_pkg::NONE;
					res_q.entry_concept <= '0;
					res_q.entry_next    <= iict_pkg::NONE;
					e_q                 <= head_rd_q;
					prev_q              <= iict_pkg::NONE;
					steps_q             <= '0;
					case (item_q.action)
						iict_pkg::ACT_HEAD: begin
							if (item_q.atom_key != '0) res_q.entry_index <= head_rd_q;
							state_q <= S_RES;
						end
						iict_pkg::ACT_READ: begin
							res_q.entry_index   <= {1'b0, item_q.entry_to_read};
							res_q.entry_concept <= con_rd_q;
							res_q.entry_next    <= link_rd_q;
							state_q             <= S_RES;
						end
						default: begin
							if (!item_q.atom_is_simple) begin
								res_q.status <= iict_pkg::ST_SKIP;
								state_q      <= S_RES;
							end else if (!head_rd_q[IW-1]) begin
								state_q <= S_FETCH;
							end else if (item_q.action == iict_pkg::ACT_ADD) begin
								state_q <= S_ALLOC;
							end else begin
								res_q.status <= iict_pkg::ST_NOTFOUND;
								state_q      <= S_RES;
							end
						end
					endcase
				end
				S_FETCH: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (con_rd_q == item_q.concept_id) begin
						if (item_q.action == iict_pkg::ACT_ADD) begin
							res_q.status      <= iict_pkg::ST_SKIP;
							res_q.entry_index <= e_q;
							state_q           <= S_RES;
						end else begin
							state_q <= S_FREE;
						end
					end else begin
						// Advance along the chain
						prev_q  <= e_q;
						e_q     <= link_rd_q;
						steps_q <= steps_q + IW'(1);
						if (!link_rd_q[IW-1] && steps_q != IW'(iict_pkg::POOL_SIZE - 1)) begin
							state_q <= S_FETCH;
						end else if (item_q.action == iict_pkg::ACT_ADD) begin
							state_q <= S_ALLOC;
						end else begin
							res_q.status <= iict_pkg::ST_NOTFOUND;
							state_q      <= S_RES;
						end
					end
				end
				S_FREE: begin
					if (free_count_q < IW'(iict_pkg::POOL_SIZE)) free_count_q <= free_count_q + IW'(1);
					res_q.status      <= iict_pkg::ST_DONE;
					res_q.entry_index <= e_q;
					state_q           <= S_RES;
				end
				S_ALLOC: begin
					if (free_count_q == '0) begin
						res_q.status <= iict_pkg::ST_EMPTY;
						state_q      <= S_RES;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					free_count_q <= free_dec;
					ne_q         <= {1'b0, free_rd_q};
					state_q      <= S_LINK;
				end
				S_LINK: begin
					res_q.status      <= iict_pkg::ST_DONE;
					res_q.entry_index <= ne_q;
					state_q           <= S_RES;
				end
				S_RES: begin
					// Hold the result until the output register is free
					if (!out_valid_q || out_ch.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
